// ----- design/upcd_pkg.sv -----
package upcd_pkg;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_BYTE   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    localparam int unsigned KEY_ROM_DEPTH = 64;
    localparam int unsigned KEY_ROM_AW    = 6;

    localparam logic [10:0] MAX_PACKAGE_BYTES = 11'd2044;
    localparam logic [31:0] BASE_ADDR_RESET   = 32'h0800_0000;

    // key text bytes, each plus 11
    localparam logic [7:0] KEY_ROM [KEY_ROM_DEPTH] = '{
        8'h5E, 8'h73, 8'h70, 8'h79, 8'h65, 8'h73, 8'h70, 8'h79, 8'h2B,
        8'h5E, 8'h7A, 8'h82, 8'h6C, 8'h84, 8'h2B,
        8'h5E, 8'h6E, 8'h74, 8'h70, 8'h79, 8'h6E, 8'h70, 8'h2B,
        8'h6C, 8'h79, 8'h6F, 8'h2B,
        8'h5F, 8'h70, 8'h6E, 8'h73, 8'h79, 8'h7A, 8'h77, 8'h7A, 8'h72, 8'h84, 8'h2B,
        8'h4F, 8'h70, 8'h81, 8'h70, 8'h77, 8'h7A, 8'h7B, 8'h78, 8'h70, 8'h79, 8'h7F, 8'h2B,
        8'h4E, 8'h7A, 8'h39, 8'h37, 8'h2B,
        8'h57, 8'h7F, 8'h6F, 8'h39,
        8'h2B, 8'h2B, 8'h2B, 8'h2B,
        8'h0B
    };

endpackage

// ----- design/upgrade_package_checker_descrambler.sv -----
// channel  handshake             payload
// -------  --------------------  ----------------------------------------------
// in       in_valid / in_stall   kind, total_packages, sequence_number,
//                                expected_sum, payload_length, data_byte
// out      out_valid / out_stall status, byte_valid, decoded_byte,
//                                write_address, package_done, image_ok
// cfg      cfg_valid / cfg_ready cfg_data (image_base_address)
//
// one item per cycle while in_stall is low; each result is registered in the
// output register as its item is taken. the key table is a synchronous rom read
// ahead at the next key position, so consecutive bytes never wait on it.
// rst_n clears all session state; no clearing pass is needed.
// in_stall rises only while a result is held and out_stall is high.
module upgrade_package_checker_descrambler #(
    parameter int unsigned KEY_LENGTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] total_packages,
    input  logic [15:0] sequence_number,
    input  logic [31:0] expected_sum,
    input  logic [10:0] payload_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic        byte_valid,
    output logic [7:0]  decoded_byte,
    output logic [31:0] write_address,
    output logic        package_done,
    output logic        image_ok
);
    import upcd_pkg::*;

    localparam int unsigned KPW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
    localparam logic [KPW-1:0] KEY_LAST = KPW'(KEY_LENGTH - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_HDR,
        PH_RECV
    } phase_t;

    phase_t          phase_reg,  phase_next;
    logic            good_reg,   good_next;
    logic [15:0]     total_reg,  total_next;
    logic [15:0]     last_reg,   last_next;
    logic [31:0]     sum_reg,    sum_next;
    logic [31:0]     target_reg, target_next;
    logic [31:0]     addr_reg,   addr_next;
    logic [KPW-1:0]  kpos_reg,   kpos_next;
    logic [10:0]     rem_reg,    rem_next;
    logic            acc_reg,    acc_next;
    logic            fin_reg,    fin_next;
    logic [31:0]     base_reg;
    logic [7:0]      key_q_reg;

    logic            out_valid_reg;
    logic            status_reg,  status_next;
    logic            bvalid_reg,  bvalid_next;
    logic [7:0]      dec_reg,     dec_next;
    logic [31:0]     waddr_reg,   waddr_next;
    logic            done_reg,    done_next;
    logic            ok_reg;

    logic            accept;
    logic            do_finish;
    logic [7:0]      kpos_wide;
    kind_t           kind_in;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign kind_in   = kind_t'(kind);
    assign kpos_wide = 8'(kpos_next);

    always_comb
    begin
        phase_next  = phase_reg;
        good_next   = good_reg;
        total_next  = total_reg;
        last_next   = last_reg;
        sum_next    = sum_reg;
        target_next = target_reg;
        addr_next   = addr_reg;
        kpos_next   = kpos_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        fin_next    = fin_reg;
        status_next = 1'b0;
        bvalid_next = 1'b0;
        dec_next    = 8'd0;
        waddr_next  = 32'd0;
        done_next   = 1'b0;
        do_finish   = 1'b0;

        if (accept)
        begin
            case (kind_in)
                KIND_CLEAR:
                begin
                    phase_next  = PH_WAIT_HDR;
                    good_next   = 1'b0;
                    total_next  = 16'd0;
                    last_next   = 16'd0;
                    sum_next    = 32'd0;
                    target_next = 32'd0;
                    addr_next   = base_reg;
                    kpos_next   = '0;
                    rem_next    = 11'd0;
                    acc_next    = 1'b0;
                    fin_next    = 1'b0;
                end
                KIND_HEADER:
                begin
                    rem_next  = payload_length;
                    acc_next  = 1'b0;
                    fin_next  = 1'b0;
                    kpos_next = '0;
                    done_next = (payload_length == 11'd0);
                    if (payload_length > MAX_PACKAGE_BYTES || phase_reg == PH_IDLE)
                    begin
                        status_next = 1'b1;
                    end
                    else if (phase_reg == PH_WAIT_HDR)
                    begin
                        phase_next  = PH_RECV;
                        total_next  = total_packages;
                        target_next = expected_sum;
                    end
                    // 17-bit compares: no header follows sequence 65535
                    else if (total_reg != total_packages
                             || ({1'b0, last_reg} + 17'd1) != {1'b0, sequence_number})
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        last_next = sequence_number;
                        acc_next  = 1'b1;
                        fin_next  = ({1'b0, total_reg} == ({1'b0, sequence_number} + 17'd1));
                        do_finish = (payload_length == 11'd0) && fin_next;
                    end
                end
                KIND_BYTE:
                begin
                    if (rem_reg == 11'd0)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        rem_next = rem_reg - 11'd1;
                        if (acc_reg)
                        begin
                            sum_next    = sum_reg + {24'd0, data_byte};
                            dec_next    = data_byte ^ key_q_reg;
                            bvalid_next = 1'b1;
                            waddr_next  = addr_reg;
                            addr_next   = addr_reg + 32'd1;
                            kpos_next   = (kpos_reg == KEY_LAST) ? '0 : kpos_reg + KPW'(1);
                        end
                        // bytes after a rejected header
                        else if (phase_reg != PH_RECV || last_reg != 16'd0
                                 || total_reg == 16'd0)
                        begin
                            status_next = 1'b1;
                        end
                        if (rem_next == 11'd0)
                        begin
                            done_next = 1'b1;
                            do_finish = acc_reg & fin_reg;
                            acc_next  = 1'b0;
                            fin_next  = 1'b0;
                        end
                    end
                end
                default:
                begin
                    status_next = 1'b1;
                end
            endcase

            if (do_finish)
            begin
                if (sum_next != target_reg)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    phase_next  = PH_IDLE;
                    good_next   = 1'b1;
                    total_next  = 16'd0;
                    last_next   = 16'd0;
                    sum_next    = 32'd0;
                    target_next = 32'd0;
                    acc_next    = 1'b0;
                    fin_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            good_reg      <= 1'b1;
            total_reg     <= 16'd0;
            last_reg      <= 16'd0;
            sum_reg       <= 32'd0;
            target_reg    <= 32'd0;
            addr_reg      <= 32'd0;
            kpos_reg      <= '0;
            rem_reg       <= 11'd0;
            acc_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            base_reg      <= BASE_ADDR_RESET;
            key_q_reg     <= KEY_ROM[0];
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b1;
        end
        else
        begin
            phase_reg  <= phase_next;
            good_reg   <= good_next;
            total_reg  <= total_next;
            last_reg   <= last_next;
            sum_reg    <= sum_next;
            target_reg <= target_next;
            addr_reg   <= addr_next;
            kpos_reg   <= kpos_next;
            rem_reg    <= rem_next;
            acc_reg    <= acc_next;
            fin_reg    <= fin_next;
            // rom read ahead, at the position the next byte uses
            key_q_reg  <= KEY_ROM[kpos_wide[KEY_ROM_AW-1:0]];
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                ok_reg        <= good_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            bvalid_reg <= bvalid_next;
            dec_reg    <= dec_next;
            waddr_reg  <= waddr_next;
            done_reg   <= done_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign byte_valid    = bvalid_reg;
    assign decoded_byte  = dec_reg;
    assign write_address = waddr_reg;
    assign package_done  = done_reg;
    assign image_ok      = ok_reg;

endmodule

// ----- design/upcd_checker.sv -----
module upcd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        status,
    input  logic        byte_valid,
    input  logic [7:0]  decoded_byte,
    input  logic [31:0] write_address
);
    import upcd_pkg::*;

    logic        out_take;
    logic        prev_byte_reg;
    logic [31:0] prev_addr_reg;

    assign out_take = out_valid & ~out_stall;

    // remembers whether the last delivered item was a decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg <= 1'b0;
            prev_addr_reg <= 32'd0;
        end
        else if (out_take)
        begin
            prev_byte_reg <= byte_valid;
            prev_addr_reg <= write_address;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(write_address)
            && $stable(decoded_byte) && $stable(status))
        else $error("held result changed while stalled");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> decoded_byte == 8'd0 && write_address == 32'd0)
        else $error("non-data item carries byte or address");

    a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && byte_valid && prev_byte_reg |-> write_address == prev_addr_reg + 32'd1)
        else $error("consecutive bytes not at consecutive addresses");

endmodule

bind upgrade_package_checker_descrambler upcd_checker u_upcd_checker (.*);

// ----- sim/upgrade_package_checker_descrambler_tb.sv -----
module upgrade_package_checker_descrambler_tb;

    import upcd_pkg::*;

    localparam logic [31:0] BASE_AT_RESET = 32'h0800_0000;
    localparam logic [10:0] PKG_LIMIT     = 11'd2044;

    localparam logic [1:0] PH_IDLE       = 2'd0;
    localparam logic [1:0] PH_WAIT_FIRST = 2'd1;
    localparam logic [1:0] PH_RECEIVING  = 2'd2;

    // key text bytes plus 11
    localparam logic [7:0] SCRAMBLE_KEY [64] = '{
        8'h5E, 8'h73, 8'h70, 8'h79, 8'h65, 8'h73, 8'h70, 8'h79, 8'h2B,
        8'h5E, 8'h7A, 8'h82, 8'h6C, 8'h84, 8'h2B,
        8'h5E, 8'h6E, 8'h74, 8'h70, 8'h79, 8'h6E, 8'h70, 8'h2B,
        8'h6C, 8'h79, 8'h6F, 8'h2B,
        8'h5F, 8'h70, 8'h6E, 8'h73, 8'h79, 8'h7A, 8'h77, 8'h7A, 8'h72, 8'h84, 8'h2B,
        8'h4F, 8'h70, 8'h81, 8'h70, 8'h77, 8'h7A, 8'h7B, 8'h78, 8'h70, 8'h79, 8'h7F,
        8'h2B,
        8'h4E, 8'h7A, 8'h39, 8'h37, 8'h2B,
        8'h57, 8'h7F, 8'h6F, 8'h39,
        8'h2B, 8'h2B, 8'h2B, 8'h2B,
        8'h0B
    };

    typedef struct {
        kind_t       kind;
        logic [15:0] total;
        logic [15:0] seq;
        logic [31:0] esum;
        logic [10:0] plen;
        logic [7:0]  dbyte;
    } link_item_t;

    typedef struct {
        logic        status;
        logic        byte_valid;
        logic [7:0]  dec;
        logic [31:0] addr;
        logic        done;
        logic        ok;
    } flash_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    kind_t       kind = KIND_CLEAR;
    logic [15:0] total_packages = '0;
    logic [15:0] sequence_number = '0;
    logic [31:0] expected_sum = '0;
    logic [10:0] payload_length = '0;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic        byte_valid;
    logic [7:0]  decoded_byte;
    logic [31:0] write_address;
    logic        package_done;
    logic        image_ok;

    upgrade_package_checker_descrambler dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .total_packages  (total_packages),
        .sequence_number (sequence_number),
        .expected_sum    (expected_sum),
        .payload_length  (payload_length),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .byte_valid      (byte_valid),
        .decoded_byte    (decoded_byte),
        .write_address   (write_address),
        .package_done    (package_done),
        .image_ok        (image_ok)
    );

    always #5 clk = ~clk;

    link_item_t   pending_items [$];
    flash_write_t expected_writes [$];
    link_item_t   on_bus;
    int           items_queued = 0;
    int           items_taken = 0;
    int           mismatches = 0;
    logic         steady = 1'b0;

    // predictor state
    logic [31:0] base_cfg = BASE_AT_RESET;
    logic [1:0]  sess_phase = PH_IDLE;
    logic        image_good = 1'b1;
    logic [15:0] total_seen = '0;
    logic [15:0] last_seq = '0;
    logic [31:0] run_sum = '0;
    logic [31:0] goal_sum = '0;
    logic [31:0] next_addr = '0;
    logic [5:0]  key_pos = '0;
    logic [10:0] bytes_left = '0;
    logic        pkg_taken = 1'b0;
    logic        pkg_final = 1'b0;

    function automatic logic close_if_sum_good();
        if (run_sum != goal_sum)
            return 1'b1;
        sess_phase = PH_IDLE;
        image_good = 1'b1;
        total_seen = '0;
        last_seq   = '0;
        run_sum    = '0;
        goal_sum   = '0;
        pkg_taken  = 1'b0;
        pkg_final  = 1'b0;
        return 1'b0;
    endfunction

    function automatic flash_write_t descramble_step(input link_item_t it);
        flash_write_t r;
        r = '{status: 1'b0, byte_valid: 1'b0, dec: 8'h00, addr: 32'h0, done: 1'b0, ok: 1'b0};
        case (it.kind)
            KIND_CLEAR: begin
                sess_phase = PH_WAIT_FIRST;
                image_good = 1'b0;
                total_seen = '0;
                last_seq   = '0;
                run_sum    = '0;
                goal_sum   = '0;
                next_addr  = base_cfg;
                key_pos    = '0;
                bytes_left = '0;
                pkg_taken  = 1'b0;
                pkg_final  = 1'b0;
            end
            KIND_HEADER: begin
                bytes_left = it.plen;
                pkg_taken  = 1'b0;
                pkg_final  = 1'b0;
                key_pos    = '0;
                r.done     = (it.plen == 11'd0);
                if (it.plen > PKG_LIMIT || sess_phase == PH_IDLE) begin
                    r.status = 1'b1;
                end
                else if (sess_phase == PH_WAIT_FIRST) begin
                    sess_phase = PH_RECEIVING;
                    total_seen = it.total;
                    goal_sum   = it.esum;
                end
                else if (total_seen != it.total
                         || {1'b0, last_seq} + 17'd1 != {1'b0, it.seq}) begin
                    r.status = 1'b1;
                end
                else begin
                    last_seq  = it.seq;
                    pkg_taken = 1'b1;
                    pkg_final = ({1'b0, total_seen} == {1'b0, it.seq} + 17'd1);
                    if (it.plen == 11'd0 && pkg_final)
                        r.status = close_if_sum_good();
                end
            end
            KIND_BYTE: begin
                if (bytes_left == 11'd0) begin
                    r.status = 1'b1;
                end
                else begin
                    bytes_left = bytes_left - 11'd1;
                    if (pkg_taken) begin
                        run_sum      = run_sum + 32'(it.dbyte);
                        r.dec        = it.dbyte ^ SCRAMBLE_KEY[key_pos];
                        r.byte_valid = 1'b1;
                        r.addr       = next_addr;
                        next_addr    = next_addr + 32'd1;
                        key_pos      = key_pos + 6'd1;
                    end
                    else if (sess_phase != PH_RECEIVING || last_seq != 16'd0
                             || total_seen == 16'd0) begin
                        // bytes behind a rejected header
                        r.status = 1'b1;
                    end
                    if (bytes_left == 11'd0) begin
                        r.done = 1'b1;
                        if (pkg_taken && pkg_final)
                            r.status = close_if_sum_good();
                        pkg_taken = 1'b0;
                        pkg_final = 1'b0;
                    end
                end
            end
            default: r.status = 1'b1;
        endcase
        r.ok = image_good;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // sender
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_writes.push_back(descramble_step(on_bus));
                items_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 38)) begin
                    on_bus = pending_items.pop_front();
                    in_valid        <= 1'b1;
                    kind            <= on_bus.kind;
                    total_packages  <= on_bus.total;
                    sequence_number <= on_bus.seq;
                    expected_sum    <= on_bus.esum;
                    payload_length  <= on_bus.plen;
                    data_byte       <= on_bus.dbyte;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk) begin
        flash_write_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end
                else begin
                    want = expected_writes.pop_front();
                    check_field("status", 32'(status), 32'(want.status));
                    check_field("byte_valid", 32'(byte_valid), 32'(want.byte_valid));
                    check_field("decoded_byte", 32'(decoded_byte), 32'(want.dec));
                    check_field("write_address", write_address, want.addr);
                    check_field("package_done", 32'(package_done), 32'(want.done));
                    check_field("image_ok", 32'(image_ok), 32'(want.ok));
                end
            end
            out_stall <= !steady && ($urandom_range(99) < 38);
        end
    end

    function automatic link_item_t random_fields(input kind_t k);
        link_item_t it;
        it.kind  = k;
        it.total = 16'($urandom);
        it.seq   = 16'($urandom);
        it.esum  = $urandom;
        it.plen  = 11'($urandom);
        it.dbyte = 8'($urandom);
        return it;
    endfunction

    task automatic queue_item(input link_item_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_kind(input kind_t k);
        queue_item(random_fields(k));
    endtask

    task automatic push_header(input logic [15:0] total, input logic [15:0] seq,
                               input logic [31:0] esum, input logic [10:0] plen);
        link_item_t it;
        it       = random_fields(KIND_HEADER);
        it.total = total;
        it.seq   = seq;
        it.esum  = esum;
        it.plen  = plen;
        queue_item(it);
    endtask

    task automatic push_byte(input logic [7:0] b);
        link_item_t it;
        it       = random_fields(KIND_BYTE);
        it.dbyte = b;
        queue_item(it);
    endtask

    // something out of order between two packages of a good image
    task automatic push_interference(input int n, input int p);
        int k;
        k = $urandom_range(0, 3);
        case ($urandom_range(3))
            0: push_kind(KIND_NONE);
            1: push_byte(8'($urandom));
            2: begin
                push_header(16'(n), 16'(p + 1 + $urandom_range(0, 2)), $urandom, 11'(k));
                repeat (k) push_byte(8'($urandom));
            end
            default: push_header(16'(n), 16'(p), $urandom, 11'($urandom_range(2045, 2047)));
        endcase
    endtask

    task automatic send_image();
        int n;
        int p;
        int j;
        int junk;
        int cut;
        int lens [6];
        logic [7:0]  body [$];
        logic [7:0]  b;
        logic [31:0] sum;
        logic [31:0] esum;
        n   = $urandom_range(2, 6);
        sum = '0;
        for (p = 1; p < n; p++) begin
            lens[p] = ($urandom_range(9) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 16);
            repeat (lens[p]) begin
                b = 8'($urandom);
                body.push_back(b);
                sum = sum + 32'(b);
            end
        end
        esum = ($urandom_range(6) == 0) ? $urandom : sum;
        junk = $urandom_range(0, 3);
        push_kind(KIND_CLEAR);
        push_header(16'(n), 16'($urandom), esum, 11'(junk));
        repeat (junk) push_byte(8'($urandom));
        for (p = 1; p < n; p++) begin
            if ($urandom_range(9) == 0)
                push_interference(n, p);
            push_header(16'(n), 16'(p), $urandom, 11'(lens[p]));
            // now and then the package is cut short by the next header
            cut = ($urandom_range(19) == 0) ? $urandom_range(0, lens[p]) : lens[p];
            for (j = 0; j < lens[p]; j++) begin
                b = body.pop_front();
                if (j < cut)
                    push_byte(b);
            end
        end
    endtask

    task automatic push_noise();
        link_item_t it;
        repeat ($urandom_range(1, 4)) begin
            it = random_fields(kind_t'($urandom_range(0, 3)));
            if ($urandom_range(3) != 0)
                it.plen = 11'($urandom_range(0, 12));
            if ($urandom_range(3) == 0)
                it.total = 16'($urandom_range(0, 2));
            queue_item(it);
        end
    endtask

    task automatic wait_quiet();
        do
            @(posedge clk);
        while (items_taken != items_queued || expected_writes.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        base_cfg = value;
    endtask

    initial begin
        logic [31:0] bases [4];
        int k;
        int goal;
        bases = '{32'hFFFF_FFF8, 32'h0000_0000, 32'hFFFF_FFFF, $urandom};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, base address left at its reset value
        push_kind(KIND_NONE);
        push_byte(8'hFF);
        push_header(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 11'd2);
        push_byte(8'h00);
        push_byte(8'h12);
        push_kind(KIND_CLEAR);
        push_header(16'd3, 16'hFFFF, 32'h0000_0200, PKG_LIMIT);
        push_byte(8'hA5);
        push_header(16'd3, 16'd1, 32'h0, 11'd2);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_header(16'd4, 16'd2, 32'h0, 11'd1);
        push_byte(8'h33);
        push_header(16'd3, 16'd2, 32'h0, 11'd2047);
        push_header(16'd3, 16'd3, 32'h0, 11'd0);
        push_header(16'd3, 16'd2, 32'h0, 11'd1);
        push_byte(8'h01);
        push_kind(KIND_CLEAR);
        push_header(16'd2, 16'd0, 32'h0, 11'd0);
        push_header(16'd2, 16'd1, 32'h0, 11'd0);
        push_kind(KIND_CLEAR);
        push_header(16'd2, 16'd0, 32'h0000_0081, 11'd0);
        push_header(16'd2, 16'd1, 32'h0, 11'd2);
        push_byte(8'h80);
        push_byte(8'h01);

        // random part in eight rounds; each round starts once all results are in
        for (k = 0; k < 8; k++) begin
            wait_quiet();
            if (k % 2 == 0)
                write_base(bases[k / 2]);
            steady = (k == 4 || k == 5);
            goal = items_queued + 200;
            while (items_queued < goal) begin
                if ($urandom_range(3) != 0)
                    send_image();
                else
                    push_noise();
            end
        end

        wait_quiet();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/upcd_pkg.sv
design/upgrade_package_checker_descrambler.sv
design/upcd_checker.sv
sim/upgrade_package_checker_descrambler_tb.sv
